// ----- rtl/gated_centroid_track_table_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Track table assertion macros
// Clocked, reset-gated property shorthands used by the track table RTL.
// ----------------------------------------------------------------------------
`ifndef GATED_CENTROID_TRACK_TABLE_UNIT_MACROS_SVH
`define GATED_CENTROID_TRACK_TABLE_UNIT_MACROS_SVH

// Invariant checked at every edge outside reset.
`define GCTT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define GCTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GCTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/gctt_pkg.sv -----
// ----------------------------------------------------------------------------
// Track table package
// Types, codes and sizes shared by the gated centroid track table.
// ----------------------------------------------------------------------------
package gctt_pkg;

	localparam int MAX_TRACKS = 32;
	localparam int IDX_W = $clog2(MAX_TRACKS);
	localparam int CNT_W = $clog2(MAX_TRACKS + 1);

	// opcodes
	localparam logic [1:0] OP_DET    = 2'd0;
	localparam logic [1:0] OP_FRAME  = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_DET    = 2'd0;
	localparam logic [1:0] KIND_SPEED  = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// detection status
	localparam logic [1:0] STAT_MATCH  = 2'd0;
	localparam logic [1:0] STAT_APPEND = 2'd1;
	localparam logic [1:0] STAT_INSERT = 2'd2;
	localparam logic [1:0] STAT_DROP   = 2'd3;

	// register indexes
	localparam logic [1:0] REG_GATE   = 2'd0;
	localparam logic [1:0] REG_MAXMISS = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;

	localparam logic [7:0]  GATE_RST    = 8'd10;
	localparam logic [3:0]  MAXMISS_RST = 4'd5;
	localparam logic [15:0] SCALE_RST   = 16'd1319;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} gctt_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [4:0]  track_position;
		logic [23:0] mean_speed;
		logic [5:0]  seen_count;
		logic [5:0]  live_count;
		logic        last;
	} gctt_out_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [31:0] dsum;
		logic [15:0] pcount;
		logic [3:0]  missed;
		logic        matched;
	} trk_entry_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_D_RD,
		ST_D_DIFF,
		ST_D_SQ,
		ST_D_CMP,
		ST_D_MISS,
		ST_D_SQRT,
		ST_D_UPD,
		ST_INS_RD,
		ST_INS_WR,
		ST_NEW_WR,
		ST_F1_RD,
		ST_F1_CHK,
		ST_F2_RD,
		ST_F2_CHK,
		ST_FL_RD,
		ST_FL_CHK,
		ST_NEXT,
		ST_SP_MUL,
		ST_SP_PREP,
		ST_SP_DIV,
		ST_SP_OUT,
		ST_SUMM,
		ST_EMIT
	} gctt_state_t;

endpackage

// ----- rtl/gated_centroid_track_table_unit.sv -----
// ----------------------------------------------------------------------------
// Gated centroid track table
// Ordered table of object tracks with gated matching, aging and speed reports.
// ----------------------------------------------------------------------------
// One item is handled at a time. A detection scans the table entry by entry
// (read, difference, square, gate compare); a match into a track not yet
// matched this frame adds a bit-serial square root, and an insert moves the
// tail of the table entry by entry (read, write). End of frame makes two
// passes over the live tracks, a counting pass (read, check) and a
// compacting pass (read, check, advance); flush makes one pass (read, check,
// advance), and every speed report adds a multiply, a rounding step, the
// 49-step restoring divider and an output step. The single-read-port track
// memory sets the per-entry steps. Results leave through an output register,
// so a new item can be taken while the last result of the previous one
// still waits for transfer. Configuration writes are always taken. No
// clearing pass is run: only entries below the live count are ever read.
// ----------------------------------------------------------------------------
module gated_centroid_track_table_unit
	import gctt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      det_valid,
	output logic      det_ready,
	input  gctt_in_t  det,
	output logic      res_valid,
	input  logic      res_ready,
	output gctt_out_t res,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic [7:0]  gate_q;
	logic [3:0]  maxmiss_q;
	logic [15:0] scale_q;

	// control
	gctt_state_t state_q, state_d, ret_q;
	logic        flush_q;
	logic [IDX_W-1:0] idx_q, wr_q;
	logic [CNT_W-1:0] total_q, keep_q, vis_q, jj_q, at_q;
	logic [1:0]  stat_q;
	logic [5:0]  step_q;

	// datapath
	logic [15:0] x_q, y_q, dx_q, dy_q;
	logic [31:0] sqx_q, sqy_q;
	logic [33:0] rad_q;
	logic [18:0] srem_q;
	logic [16:0] root_q;
	logic [47:0] prod_q;
	logic [48:0] num_q;
	logic [19:0] den_q, drem_q;
	trk_entry_t  ent_q, mem_rd_q;
	gctt_out_t   pend_q, res_q;
	logic        res_valid_q;

	// track memory
	trk_entry_t mem [MAX_TRACKS];
	logic       mem_re, mem_we;
	logic [IDX_W-1:0] mem_ra, mem_wa;
	trk_entry_t mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	assign cfg_ready = 1'b1;
	assign det_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q    <= GATE_RST;
			maxmiss_q <= MAXMISS_RST;
			scale_q   <= SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GATE:    gate_q <= cfg_data[7:0];
				REG_MAXMISS: maxmiss_q <= cfg_data[3:0];
				REG_SCALE:   scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// gate compare: dx^2 + dy^2 < (16 * gate)^2
	logic [32:0] d2;
	logic [15:0] gsq;
	logic        hit;
	assign d2  = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign gsq = 16'(gate_q) * 16'(gate_q);
	assign hit = d2 < {9'd0, gsq, 8'd0};

	// square root step, two radicand bits per cycle
	logic [18:0] srem_n, trial;
	logic        s_ge;
	assign srem_n = {srem_q[16:0], rad_q[33:32]};
	assign trial  = {root_q, 2'b01};
	assign s_ge   = srem_n >= trial;

	// divider step, one quotient bit per cycle
	logic [20:0] dr;
	logic        d_ge;
	assign dr   = {drem_q, num_q[48]};
	assign d_ge = dr >= {1'b0, den_q};

	// aging of the entry being read
	logic [3:0] miss_inc, miss_new;
	logic       gone;
	assign miss_inc = (mem_rd_q.missed == 4'hF) ? 4'hF : mem_rd_q.missed + 4'd1;
	assign miss_new = mem_rd_q.matched ? 4'd0 : miss_inc;
	assign gone     = !mem_rd_q.matched && (miss_inc > maxmiss_q);

	// match update
	logic [32:0] sum_s;
	trk_entry_t  upd_ent, new_ent, aged_ent;
	always_comb begin
		sum_s = {1'b0, ent_q.dsum} + {16'd0, root_q};
		upd_ent = ent_q;
		upd_ent.pos_x = x_q;
		upd_ent.pos_y = y_q;
		upd_ent.dsum = sum_s[32] ? 32'hFFFF_FFFF : sum_s[31:0];
		upd_ent.pcount = (ent_q.pcount == 16'hFFFF) ? 16'hFFFF : ent_q.pcount + 16'd1;
		upd_ent.matched = 1'b1;
		new_ent = '{pos_x: x_q, pos_y: y_q, dsum: 32'd0, pcount: 16'd1,
			missed: 4'd0, matched: 1'b1};
		aged_ent = mem_rd_q;
		aged_ent.missed = miss_new;
		aged_ent.matched = 1'b0;
	end

	logic [15:0] cm1;
	logic [CNT_W-1:0] jj_m1, idx_p1;
	logic        idx_end, emit_ok;
	assign cm1     = ent_q.pcount - 16'd1;
	assign jj_m1   = jj_q - CNT_W'(1);
	assign idx_p1  = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_end = idx_p1 == total_q;
	assign emit_ok = !res_valid_q || res_ready;

	// next state and memory strobes
	always_comb begin
		state_d = state_q;
		mem_re = 1'b0;
		mem_ra = idx_q;
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = ent_q;
		unique case (state_q)
			ST_IDLE: begin
				if (det_valid) begin
					case (det.opcode)
						OP_DET:   state_d = (total_q == '0) ? ST_D_MISS : ST_D_RD;
						OP_FRAME: state_d = (total_q == '0) ? ST_SUMM : ST_F1_RD;
						OP_FLUSH: state_d = (total_q == '0) ? ST_SUMM : ST_FL_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_D_RD: begin
				mem_re = 1'b1;
				state_d = ST_D_DIFF;
			end
			ST_D_DIFF: state_d = ST_D_SQ;
			ST_D_SQ:   state_d = ST_D_CMP;
			ST_D_CMP: begin
				if (hit) begin
					if (!ent_q.matched) begin
						state_d = ST_D_SQRT;
					end else if (total_q < CNT_W'(MAX_TRACKS)) begin
						state_d = ST_INS_RD;
					end else begin
						state_d = ST_EMIT;
					end
				end else if (idx_end) begin
					state_d = ST_D_MISS;
				end else begin
					state_d = ST_D_RD;
				end
			end
			ST_D_MISS: state_d = (total_q < CNT_W'(MAX_TRACKS)) ? ST_INS_RD : ST_EMIT;
			ST_D_SQRT: if (step_q == 6'd16) state_d = ST_D_UPD;
			ST_D_UPD: begin
				mem_we = 1'b1;
				mem_wd = upd_ent;
				state_d = ST_EMIT;
			end
			ST_INS_RD: begin
				if (jj_q == at_q) begin
					state_d = ST_NEW_WR;
				end else begin
					mem_re = 1'b1;
					mem_ra = jj_m1[IDX_W-1:0];
					state_d = ST_INS_WR;
				end
			end
			ST_INS_WR: begin
				mem_we = 1'b1;
				mem_wa = jj_q[IDX_W-1:0];
				mem_wd = mem_rd_q;
				state_d = ST_INS_RD;
			end
			ST_NEW_WR: begin
				mem_we = 1'b1;
				mem_wa = at_q[IDX_W-1:0];
				mem_wd = new_ent;
				state_d = ST_EMIT;
			end
			ST_F1_RD: begin
				mem_re = 1'b1;
				state_d = ST_F1_CHK;
			end
			ST_F1_CHK: state_d = idx_end ? ST_F2_RD : ST_F1_RD;
			ST_F2_RD: begin
				mem_re = 1'b1;
				state_d = ST_F2_CHK;
			end
			ST_F2_CHK: begin
				if (!gone) begin
					mem_we = 1'b1;
					mem_wa = wr_q;
					mem_wd = aged_ent;
					state_d = ST_NEXT;
				end else begin
					state_d = (mem_rd_q.pcount >= 16'd2) ? ST_SP_MUL : ST_NEXT;
				end
			end
			ST_FL_RD: begin
				mem_re = 1'b1;
				state_d = ST_FL_CHK;
			end
			ST_FL_CHK: state_d = (mem_rd_q.pcount >= 16'd2) ? ST_SP_MUL : ST_NEXT;
			ST_NEXT: begin
				if (idx_end) begin
					state_d = ST_SUMM;
				end else begin
					state_d = flush_q ? ST_FL_RD : ST_F2_RD;
				end
			end
			ST_SP_MUL:  state_d = ST_SP_PREP;
			ST_SP_PREP: state_d = ST_SP_DIV;
			ST_SP_DIV:  if (step_q == 6'd48) state_d = ST_SP_OUT;
			ST_SP_OUT:  state_d = ST_EMIT;
			ST_SUMM:    state_d = ST_EMIT;
			ST_EMIT:    if (emit_ok) state_d = ret_q;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && emit_ok) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_ok) begin
			res_q <= pend_q;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ret_q   <= ST_IDLE;
			flush_q <= 1'b0;
			idx_q   <= '0;
			wr_q    <= '0;
			keep_q  <= '0;
			vis_q   <= '0;
			jj_q    <= '0;
			at_q    <= '0;
			stat_q  <= STAT_MATCH;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					wr_q    <= '0;
					keep_q  <= '0;
					vis_q   <= '0;
					flush_q <= (det.opcode == OP_FLUSH);
				end
				ST_D_CMP: begin
					if (hit) begin
						step_q <= '0;
						at_q   <= idx_p1;
						jj_q   <= total_q;
						stat_q <= STAT_INSERT;
						ret_q  <= ST_IDLE;
					end else if (!idx_end) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_D_MISS: begin
					at_q   <= total_q;
					jj_q   <= total_q;
					stat_q <= STAT_APPEND;
					ret_q  <= ST_IDLE;
				end
				ST_D_SQRT: step_q <= step_q + 6'd1;
				ST_INS_WR: jj_q <= jj_m1;
				ST_NEW_WR: total_q <= total_q + CNT_W'(1);
				ST_F1_CHK: begin
					if (mem_rd_q.matched) begin
						vis_q <= vis_q + CNT_W'(1);
					end
					if (!gone) begin
						keep_q <= keep_q + CNT_W'(1);
					end
					idx_q <= idx_end ? '0 : idx_q + IDX_W'(1);
				end
				ST_F2_CHK: begin
					if (!gone) begin
						wr_q <= wr_q + IDX_W'(1);
					end
				end
				ST_NEXT: begin
					if (!idx_end) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_SP_PREP: step_q <= '0;
				ST_SP_DIV:  step_q <= step_q + 6'd1;
				ST_SP_OUT:  ret_q <= ST_NEXT;
				ST_SUMM: begin
					total_q <= flush_q ? '0 : keep_q;
					ret_q   <= ST_IDLE;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= det.pos_x;
				y_q <= det.pos_y;
			end
			ST_D_DIFF: begin
				ent_q <= mem_rd_q;
				dx_q <= (x_q > mem_rd_q.pos_x) ? x_q - mem_rd_q.pos_x : mem_rd_q.pos_x - x_q;
				dy_q <= (y_q > mem_rd_q.pos_y) ? y_q - mem_rd_q.pos_y : mem_rd_q.pos_y - y_q;
			end
			ST_D_SQ: begin
				sqx_q <= 32'(dx_q) * 32'(dx_q);
				sqy_q <= 32'(dy_q) * 32'(dy_q);
			end
			ST_D_CMP: begin
				rad_q  <= {1'b0, d2};
				srem_q <= '0;
				root_q <= '0;
				pend_q <= '{kind: KIND_DET, status: STAT_DROP, track_position: 5'(idx_q),
					mean_speed: 24'd0, seen_count: 6'd0, live_count: 6'(total_q),
					last: 1'b1};
			end
			ST_D_MISS: begin
				pend_q <= '{kind: KIND_DET, status: STAT_DROP, track_position: 5'd0,
					mean_speed: 24'd0, seen_count: 6'd0, live_count: 6'(total_q),
					last: 1'b1};
			end
			ST_D_SQRT: begin
				rad_q <= {rad_q[31:0], 2'b00};
				if (s_ge) begin
					srem_q <= srem_n - trial;
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					srem_q <= srem_n;
					root_q <= {root_q[15:0], 1'b0};
				end
			end
			ST_D_UPD: begin
				pend_q <= '{kind: KIND_DET, status: STAT_MATCH, track_position: 5'(idx_q),
					mean_speed: 24'd0, seen_count: 6'd0, live_count: 6'(total_q),
					last: 1'b1};
			end
			ST_NEW_WR: begin
				pend_q <= '{kind: KIND_DET, status: stat_q, track_position: 5'(at_q),
					mean_speed: 24'd0, seen_count: 6'd0,
					live_count: 6'(total_q + CNT_W'(1)), last: 1'b1};
			end
			ST_F2_CHK, ST_FL_CHK: ent_q <= mem_rd_q;
			ST_SP_MUL: prod_q <= 48'(ent_q.dsum) * 48'(scale_q);
			ST_SP_PREP: begin
				// round half up: add den/2 before dividing by den = 16 * (count - 1)
				num_q  <= {1'b0, prod_q} + 49'({cm1, 3'b000});
				den_q  <= {cm1, 4'b0000};
				drem_q <= '0;
			end
			ST_SP_DIV: begin
				drem_q <= d_ge ? 20'(dr - {1'b0, den_q}) : dr[19:0];
				num_q  <= {num_q[47:0], d_ge};
			end
			ST_SP_OUT: begin
				pend_q <= '{kind: KIND_SPEED, status: STAT_MATCH,
					track_position: 5'(idx_q),
					mean_speed: (|num_q[48:24]) ? 24'hFF_FFFF : num_q[23:0],
					seen_count: 6'd0,
					live_count: flush_q ? 6'd0 : 6'(keep_q), last: 1'b0};
			end
			ST_SUMM: begin
				pend_q <= '{kind: KIND_SUMMARY, status: STAT_MATCH, track_position: 5'd0,
					mean_speed: 24'd0,
					seen_count: flush_q ? 6'd0 : 6'(vis_q),
					live_count: flush_q ? 6'd0 : 6'(keep_q), last: 1'b1};
			end
			default: ;
		endcase
	end

	`include "gated_centroid_track_table_unit_macros.svh"

	`GCTT_ASSERT_ALWAYS(a_total_bound, total_q <= CNT_W'(MAX_TRACKS), "live count over table size")
	`GCTT_ASSERT_IMP(a_new_room, state_q == ST_NEW_WR, total_q < CNT_W'(MAX_TRACKS), "new track into full table")
	`GCTT_ASSERT_IMP(a_compact_order, state_q == ST_F2_CHK, wr_q <= idx_q, "compaction overtook read index")
	`GCTT_ASSERT_IMP(a_keep_bound, state_q == ST_F2_CHK, keep_q <= total_q, "kept tracks exceed live tracks")
	`GCTT_ASSERT_NXT(a_det_busy, det_valid && det_ready && det.opcode == OP_DET, state_q != ST_IDLE, "detection not started")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Track table regression bench
// Drives detections, frame ends and flushes into the gated centroid track
// table. A cycle-free shadow of the table predicts every result, and a result
// monitor compares each transfer field by field against the oldest prediction.
// The run covers directed corner cases, a full table, long output back-pressure
// and random tracked-object scenes under several idle/stall mixes and register
// settings.
// ----------------------------------------------------------------------------
module testbench;
	import gctt_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int NUM_OBJS       = 8;

	logic        clk;
	logic        arst_n;
	logic        det_valid;
	logic        det_ready;
	gctt_in_t    det;
	logic        res_valid;
	logic        res_ready;
	gctt_out_t   res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	gated_centroid_track_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.det_valid (det_valid),
		.det_ready (det_ready),
		.det       (det),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the table and its registers.
	trk_entry_t  shadow_trk [MAX_TRACKS];
	int          shadow_total;
	logic [7:0]  shadow_gate;
	logic [3:0]  shadow_maxmiss;
	logic [15:0] shadow_scale;

	// Results still owed by the block, oldest first.
	gctt_out_t   pending_results [$];

	int          error_count;
	int          items_sent;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_left;      // receiver hold-off, counted down by the monitor
	int          quiet_cycles;   // cycles with no transfer on any channel

	// Scene objects for the random part (Q12.4 positions).
	int          obj_x [NUM_OBJS];
	int          obj_y [NUM_OBJS];
	bit          obj_on [NUM_OBJS];

	// ------------------------------------------------------------------
	// Clock, reset, default drive
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		det_valid = 1'b0;
		det       = '0;
		res_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GATE;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------
	function automatic longint unsigned dist_sq(int i, logic [15:0] x, logic [15:0] y);
		longint unsigned dx;
		longint unsigned dy;
		dx = (x > shadow_trk[i].pos_x) ? x - shadow_trk[i].pos_x : shadow_trk[i].pos_x - x;
		dy = (y > shadow_trk[i].pos_y) ? y - shadow_trk[i].pos_y : shadow_trk[i].pos_y - y;
		return dx * dx + dy * dy;
	endfunction

	// avg speed, half rounds up, saturates at 24 bits
	function automatic logic [23:0] track_speed(int i);
		longint unsigned den;
		longint unsigned q;
		den = 16 * (longint'(shadow_trk[i].pcount) - 1);
		q = (longint'(shadow_trk[i].dsum) * shadow_scale + den / 2) / den;
		return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
	endfunction

	function automatic void push_result(logic [1:0] kind, logic [1:0] status, int pos,
			logic [23:0] spd, int vis, int live, logic last);
		gctt_out_t r;
		r.kind           = kind;
		r.status         = status;
		r.track_position = pos[4:0];
		r.mean_speed     = spd;
		r.seen_count     = vis[5:0];
		r.live_count     = live[5:0];
		r.last           = last;
		pending_results = {pending_results, r};
	endfunction

	// open a fresh single-point track at slot 'at', shifting the tail up
	function automatic void open_track(int at, logic [15:0] x, logic [15:0] y);
		for (int j = shadow_total; j > at; j--)
			shadow_trk[j] = shadow_trk[j - 1];
		shadow_trk[at].pos_x   = x;
		shadow_trk[at].pos_y   = y;
		shadow_trk[at].dsum    = '0;
		shadow_trk[at].pcount  = 16'd1;
		shadow_trk[at].missed  = '0;
		shadow_trk[at].matched = 1'b1;
		shadow_total++;
	endfunction

	// tracks at or after slot i that the frame end removes
	function automatic int count_gone_after(bit gone [MAX_TRACKS], int i);
		int c;
		c = 0;
		for (int j = i; j < shadow_total; j++)
			if (gone[j]) c++;
		return c;
	endfunction

	function automatic void predict_item(gctt_in_t it);
		int              i;
		int              vis;
		int              keep;
		longint unsigned gsq;
		longint unsigned d2;
		longint unsigned root;
		longint unsigned sum;
		bit              gone [MAX_TRACKS];
		case (it.opcode)
			OP_DET: begin
				gsq = longint'(shadow_gate) * 16;
				gsq = gsq * gsq;
				for (i = 0; i < shadow_total; i++)
					if (dist_sq(i, it.pos_x, it.pos_y) < gsq) break;
				if (i < shadow_total) begin
					if (!shadow_trk[i].matched) begin
						d2 = dist_sq(i, it.pos_x, it.pos_y);
						root = 0;
						for (int b = 20; b >= 0; b--)
							if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= d2)
								root |= 64'd1 << b;
						sum = longint'(shadow_trk[i].dsum) + root;
						shadow_trk[i].dsum = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
						if (shadow_trk[i].pcount != 16'hFFFF)
							shadow_trk[i].pcount++;
						shadow_trk[i].pos_x   = it.pos_x;
						shadow_trk[i].pos_y   = it.pos_y;
						shadow_trk[i].matched = 1'b1;
						push_result(KIND_DET, STAT_MATCH, i, '0, 0, shadow_total, 1'b1);
					end else if (shadow_total < MAX_TRACKS) begin
						open_track(i + 1, it.pos_x, it.pos_y);
						push_result(KIND_DET, STAT_INSERT, i + 1, '0, 0, shadow_total, 1'b1);
					end else begin
						push_result(KIND_DET, STAT_DROP, i, '0, 0, shadow_total, 1'b1);
					end
				end else if (shadow_total < MAX_TRACKS) begin
					open_track(shadow_total, it.pos_x, it.pos_y);
					push_result(KIND_DET, STAT_APPEND, shadow_total - 1, '0, 0,
						shadow_total, 1'b1);
				end else begin
					push_result(KIND_DET, STAT_DROP, 0, '0, 0, shadow_total, 1'b1);
				end
			end
			OP_FRAME: begin
				vis  = 0;
				keep = 0;
				for (i = 0; i < shadow_total; i++) begin
					gone[i] = 1'b0;
					if (shadow_trk[i].matched) begin
						shadow_trk[i].missed = '0;
						vis++;
					end else begin
						if (shadow_trk[i].missed != 4'd15)
							shadow_trk[i].missed++;
						gone[i] = shadow_trk[i].missed > shadow_maxmiss;
					end
					if (!gone[i])
						keep++;
				end
				// reports carry the live count after removal
				keep = 0;
				for (i = 0; i < shadow_total; i++) begin
					if (gone[i]) begin
						if (shadow_trk[i].pcount >= 2)
							push_result(KIND_SPEED, STAT_MATCH, i, track_speed(i), 0,
								shadow_total - (i - keep) - count_gone_after(gone, i), 1'b0);
					end else begin
						shadow_trk[keep] = shadow_trk[i];
						shadow_trk[keep].matched = 1'b0;
						keep++;
					end
				end
				shadow_total = keep;
				push_result(KIND_SUMMARY, STAT_MATCH, 0, '0, vis, keep, 1'b1);
			end
			OP_FLUSH: begin
				for (i = 0; i < shadow_total; i++)
					if (shadow_trk[i].pcount >= 2)
						push_result(KIND_SPEED, STAT_MATCH, i, track_speed(i), 0, 0, 1'b0);
				shadow_total = 0;
				push_result(KIND_SUMMARY, STAT_MATCH, 0, '0, 0, 0, 1'b1);
			end
			default: ;  // unused opcode: ignored
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result monitor: receiver stalls and compares each transfer
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
	endtask

	initial begin
		gctt_out_t want;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, kind", res.kind, -1);
				end else begin
					want = pending_results.pop_front();
					if (res.kind != want.kind)
						report_mismatch("kind", res.kind, want.kind);
					if (res.status != want.status)
						report_mismatch("status", res.status, want.status);
					if (res.track_position != want.track_position)
						report_mismatch("track_position", res.track_position,
							want.track_position);
					if (res.mean_speed != want.mean_speed)
						report_mismatch("mean_speed", res.mean_speed, want.mean_speed);
					if (res.seen_count != want.seen_count)
						report_mismatch("seen_count", res.seen_count,
							want.seen_count);
					if (res.live_count != want.live_count)
						report_mismatch("live_count", res.live_count, want.live_count);
					if (res.last != want.last)
						report_mismatch("last", res.last, want.last);
				end
			end
			if (!arst_n) begin
				res_ready <= 1'b0;
			end else if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else begin
				res_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: nothing transferred for too long ends the run
	// ------------------------------------------------------------------
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((det_valid && det_ready) || (res_valid && res_ready) ||
					(cfg_valid && cfg_ready) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// One input transfer. Valid is left high after the transfer so that a
	// back-to-back item never lowers and raises it in the same step.
	task automatic send_item(logic [1:0] op, logic [15:0] x, logic [15:0] y);
		gctt_in_t it;
		it.opcode = op;
		it.pos_x  = x;
		it.pos_y  = y;
		while ($urandom_range(99) < send_idle_pct) begin
			det_valid <= 1'b0;
			@(posedge clk);
		end
		det_valid <= 1'b1;
		det       <= it;
		do @(posedge clk); while (!det_ready);
		predict_item(it);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Wait until every owed result has been taken and the block is idle.
	task automatic drain();
		det_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GATE:    shadow_gate    = value[7:0];
			REG_MAXMISS: shadow_maxmiss = value[3:0];
			REG_SCALE:   shadow_scale   = value;
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		send_item(OP_FRAME, 16'd0, 16'd0);          // frame end on an empty table
		send_item(OP_FLUSH, 16'd0, 16'd0);          // flush of an empty table
		send_item(OP_DET, 16'd0, 16'd0);            // append
		send_item(OP_DET, 16'd159, 16'd0);          // near an already matched track: insert
		send_item(OP_DET, 16'hFFFF, 16'hFFFF);      // far corner: append
		send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);   // unused opcode
		send_item(OP_FRAME, 16'hFFFF, 16'h0000);
		send_item(OP_DET, 16'd159, 16'd0);          // just inside the gate: match
		send_item(OP_DET, 16'd113, 16'd113);        // diagonal, inside the gate
		send_item(OP_DET, 16'hFFFF, 16'hFF60);      // just inside the gate of the corner track: match
		send_item(OP_FRAME, 16'd0, 16'd0);
		send_item(OP_DET, 16'hFF70, 16'hFFFF);
		send_item(OP_FLUSH, 16'd0, 16'd0);          // speed reports then summary
		send_item(OP_DET, 16'h5555, 16'hAAAA);
		send_item(OP_DET, 16'h5560, 16'hAAA0);
		send_item(OP_FRAME, 16'd0, 16'd0);
		for (int k = 0; k < 7; k++)                 // age out past the default limit
			send_item(OP_FRAME, 16'd0, 16'd0);
	endtask

	task automatic test_table_full();
		// 32 widely spaced tracks, then appends and inserts are dropped
		for (int k = 0; k < MAX_TRACKS + 2; k++)
			send_item(OP_DET, 16'(k * 1024), 16'(k * 1800));
		send_item(OP_DET, 16'd10, 16'd0);           // near an already matched track: insert dropped, table full
		send_item(OP_FRAME, 16'd0, 16'd0);
		send_item(OP_DET, 16'd1030, 16'd1800);      // match after frame end
		send_item(OP_DET, 16'd1020, 16'd1795);      // insert attempt, table full
		send_item(OP_FLUSH, 16'd0, 16'd0);
	endtask

	task automatic test_backpressure();
		hold_left = 600;
		for (int k = 0; k < 30; k++)
			send_item(k % 6 == 5 ? OP_FRAME : OP_DET, 16'($urandom_range(4000)),
				16'($urandom_range(4000)));
		send_item(OP_FLUSH, 16'd0, 16'd0);
	endtask

	// Random scenes: objects wander under the gate, mostly detected, with
	// frame ends, occasional flushes and some noise.
	task automatic run_scenes(int target);
		int step;
		int noise;
		step = (shadow_gate == 0) ? 64 : int'(shadow_gate) * 8;
		for (int o = 0; o < NUM_OBJS; o++) begin
			obj_on[o] = $urandom_range(1);
			obj_x[o]  = $urandom_range(65535);
			obj_y[o]  = $urandom_range(65535);
		end
		target += items_sent;
		while (items_sent < target) begin
			for (int o = 0; o < NUM_OBJS; o++) begin
				if ($urandom_range(99) < 8) begin
					obj_on[o] = !obj_on[o];
					obj_x[o]  = $urandom_range(65535);
					obj_y[o]  = $urandom_range(65535);
				end
				obj_x[o] += int'($urandom_range(2 * step)) - step;
				obj_y[o] += int'($urandom_range(2 * step)) - step;
				if (obj_x[o] < 0) obj_x[o] = 0;
				if (obj_x[o] > 65535) obj_x[o] = 65535;
				if (obj_y[o] < 0) obj_y[o] = 0;
				if (obj_y[o] > 65535) obj_y[o] = 65535;
				if (obj_on[o] && $urandom_range(99) < 80)
					send_item(OP_DET, 16'(obj_x[o]), 16'(obj_y[o]));
				noise = $urandom_range(99);
				if (noise < 6)
					send_item(OP_DET, 16'($urandom), 16'($urandom));
				else if (noise < 7)
					send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom));
			end
			send_item($urandom_range(99) < 7 ? OP_FLUSH : OP_FRAME, 16'($urandom),
				16'($urandom));
		end
	endtask

	task automatic test_register_sweep();
		write_reg(REG_GATE, 16'd255);
		write_reg(REG_MAXMISS, 16'd0);
		write_reg(REG_SCALE, 16'd65535);
		send_idle_pct = 0;  recv_stall_pct = 0;
		run_scenes(110);
		write_reg(REG_GATE, 16'd1);
		write_reg(REG_MAXMISS, 16'd15);      // tracks never age out
		write_reg(REG_SCALE, 16'd1);
		send_idle_pct = 53; recv_stall_pct = 0;
		run_scenes(110);
		write_reg(REG_GATE, 16'd0);           // nothing matches
		write_reg(REG_MAXMISS, 16'd14);
		write_reg(REG_SCALE, 16'd0);
		send_idle_pct = 0;  recv_stall_pct = 53;
		run_scenes(50);
		write_reg(REG_GATE, 16'd10);
		write_reg(REG_MAXMISS, 16'd2);
		write_reg(REG_SCALE, 16'd1319);
		send_idle_pct = 16; recv_stall_pct = 16;
		run_scenes(110);
		send_item(OP_FLUSH, 16'd0, 16'd0);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		error_count    = 0;
		items_sent     = 0;
		hold_left      = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		shadow_total   = 0;
		shadow_gate    = GATE_RST;
		shadow_maxmiss = MAXMISS_RST;
		shadow_scale   = SCALE_RST;
		for (int i = 0; i < MAX_TRACKS; i++)
			shadow_trk[i] = '0;
		@(posedge arst_n);
		@(posedge clk);

		test_directed();
		send_idle_pct = 16; recv_stall_pct = 16;
		test_table_full();
		send_idle_pct = 0;  recv_stall_pct = 0;
		test_backpressure();
		test_register_sweep();

		drain();
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gctt_pkg.sv
rtl/gated_centroid_track_table_unit.sv
tb/testbench.sv
